// File: sv/box_frustum_visibility_test_defines.svh
// Assertion macros for the file that checks this block.
`ifndef BOX_FRUSTUM_VISIBILITY_TEST_DEFINES_SVH
`define BOX_FRUSTUM_VISIBILITY_TEST_DEFINES_SVH

// Plain property, clocked on clk_i and quiet during reset.
`define BFVT_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bfvt check failed");

// Same-cycle implication.
`define BFVT_CHECK_NOW(lbl, ante, cons) \
  `BFVT_CHECK(lbl, (ante) |-> (cons))

// Next-cycle implication.
`define BFVT_CHECK_NEXT(lbl, ante, cons) \
  `BFVT_CHECK(lbl, (ante) |=> (cons))

`endif

// File: sv/bfvt_pkg.sv
package bfvt_pkg;

  // Field and register geometry.
  localparam int GRID_W     = 11;
  localparam int FIELD_W    = 16;
  localparam int FRAC_W     = 14;
  localparam int REG_W      = 64;
  localparam int NUM_PLANES = 6;
  localparam int NUM_REGS   = 7;
  localparam int VIEW_REG   = 6;
  localparam int RANGE_SLOT = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_AXES   = 3;

  // Chunk edge sizes in world units.
  localparam int EDGE_X = 16;
  localparam int EDGE_Y = 16;
  localparam int EDGE_Z = 16;

  localparam int EDGE_XY  = (EDGE_X > EDGE_Y) ? EDGE_X : EDGE_Y;
  localparam int EDGE_MAX = (EDGE_XY > EDGE_Z) ? EDGE_XY : EDGE_Z;

  // Box corner coordinates: |grid * edge + edge| <= 2^(GRID_W-1) * edge.
  localparam int COORD_W = GRID_W + $clog2(EDGE_MAX) + 1;

  // Camera window bounds are a 16-bit signed value plus or minus a 16-bit range.
  localparam int WIN_W = FIELD_W + 2;
  localparam int CMP_W = ((COORD_W > WIN_W) ? COORD_W : WIN_W) + 1;

  // Plane products and their sum with the offset scaled by 2^FRAC_W.
  localparam int PROD_W = FIELD_W + COORD_W;
  localparam int OFS_W  = FIELD_W + FRAC_W;
  localparam int SUM_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0] coord3_t;

  // Stage advance strobes handed to the plane units.
  typedef struct packed {
    logic st2;
    logic st3;
  } adv_t;

endpackage

// File: sv/bfvt_plane.sv
module bfvt_plane (
  input  logic                      clk_i,
  input  bfvt_pkg::adv_t            adv_i,
  input  logic [bfvt_pkg::REG_W-1:0] plane_i,
  input  bfvt_pkg::coord3_t         lo_i,
  input  bfvt_pkg::coord3_t         hi_i,
  output logic                      cull_o
);
  import bfvt_pkg::*;

  logic signed [PROD_W-1:0]  prod_d [NUM_AXES];
  logic signed [PROD_W-1:0]  prod_q [NUM_AXES];
  logic signed [FIELD_W-1:0] ofs_q;
  logic signed [SUM_W-1:0]   sum;
  logic                      cull_q;

  // Each axis takes the corner end that makes its term largest.
  always_comb begin
    logic signed [FIELD_W-1:0] n;
    coord_t                    c;
    for (int a = 0; a < NUM_AXES; a++) begin
      n = $signed(plane_i[FIELD_W*a +: FIELD_W]);
      c = (n > 0) ? $signed(hi_i[a]) : $signed(lo_i[a]);
      prod_d[a] = PROD_W'(n) * PROD_W'(c);
    end
  end

  // Product stage.
  always_ff @(posedge clk_i) begin
    if (adv_i.st2) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_q[a] <= prod_d[a];
      end
      ofs_q <= $signed(plane_i[FIELD_W*RANGE_SLOT +: FIELD_W]);
    end
  end

  // Sum with the offset in Q14 and test the sign.
  assign sum = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2])
             + $signed({{(SUM_W-OFS_W){ofs_q[FIELD_W-1]}}, ofs_q, {FRAC_W{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (adv_i.st3) begin
      cull_q <= sum[SUM_W-1];
    end
  end

  assign cull_o = cull_q;

endmodule

// File: sv/box_frustum_visibility_test.sv
// Chunk visibility test against a six-plane frustum and a far-range cube.
// One chunk is accepted per cycle when the output side does not stall; its
// verdict passes through four register stages (box bounds, range check with
// plane products, plane sums, output), and each stage holds its item while
// the next one is full.
// Configuration writes are taken at once (cfg_ready_o is always high) and must
// only be issued while no chunk is in flight. visible_o is 0 when the chunk is
// disabled, lies wholly outside the cube of half-width far range around the
// camera, or has all eight box corners below zero on any one plane.
module box_frustum_visibility_test (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [bfvt_pkg::GRID_W-1:0] grid_x_i,
  input  logic signed [bfvt_pkg::GRID_W-1:0] grid_y_i,
  input  logic signed [bfvt_pkg::GRID_W-1:0] grid_z_i,
  input  logic                             draw_allowed_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             visible_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bfvt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bfvt_pkg::REG_W-1:0]       cfg_data_i
);
  import bfvt_pkg::*;

  logic [REG_W-1:0] cfg_q [NUM_REGS];

  logic    v1_q, v2_q, v3_q, vo_q;
  logic    rdy1, rdy2, rdy3, rdy_o;
  coord3_t lo_d, hi_d, lo_q, hi_q;
  logic    draw_q, keep2_q, keep3_q, vis_q;
  logic    range_ok;
  logic [NUM_PLANES-1:0] cull;
  adv_t    adv;

  // Register file writes; indexes past the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        cfg_q[r] <= '0;
      end
    end else if (cfg_valid_i) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        if (cfg_index_i == CFG_IDX_W'(r)) begin
          cfg_q[r] <= cfg_data_i;
        end
      end
    end
  end

  // Each stage moves when it is empty or the stage after it moves.
  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy3       = !v3_q || rdy_o;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign adv.st2    = rdy2;
  assign adv.st3    = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q <= in_valid_i;
      if (rdy2)  v2_q <= v1_q;
      if (rdy3)  v3_q <= v2_q;
      if (rdy_o) vo_q <= v3_q;
    end
  end

  // Stage 1: box bounds from the grid position.
  always_comb begin
    lo_d[0] = coord_t'(grid_x_i) * coord_t'(EDGE_X);
    lo_d[1] = coord_t'(grid_y_i) * coord_t'(EDGE_Y);
    lo_d[2] = coord_t'(grid_z_i) * coord_t'(EDGE_Z);
    hi_d[0] = $signed(lo_d[0]) + coord_t'(EDGE_X);
    hi_d[1] = $signed(lo_d[1]) + coord_t'(EDGE_Y);
    hi_d[2] = $signed(lo_d[2]) + coord_t'(EDGE_Z);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      draw_q <= draw_allowed_i;
    end
  end

  // Stage 2: far-range cube check, inclusive on both faces.
  always_comb begin
    logic signed [CMP_W-1:0] cam, rng, lo_x, hi_x;
    range_ok = 1'b1;
    rng = CMP_W'($signed({1'b0, cfg_q[VIEW_REG][FIELD_W*RANGE_SLOT +: FIELD_W]}));
    for (int a = 0; a < NUM_AXES; a++) begin
      cam  = CMP_W'($signed(cfg_q[VIEW_REG][FIELD_W*a +: FIELD_W]));
      lo_x = CMP_W'($signed(lo_q[a]));
      hi_x = CMP_W'($signed(hi_q[a]));
      if (hi_x < cam - rng || lo_x > cam + rng) begin
        range_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) keep2_q <= draw_q && range_ok;
    if (rdy3) keep3_q <= keep2_q;
    if (rdy_o) vis_q  <= keep3_q && !(|cull);
  end

  // Plane units: products in stage 2, sums and sign in stage 3.
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    bfvt_plane u_plane (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .plane_i (cfg_q[p]),
      .lo_i    (lo_q),
      .hi_i    (hi_q),
      .cull_o  (cull[p])
    );
  end

  assign out_valid_o = vo_q;
  assign visible_o   = vis_q;

endmodule

// File: sv/bfvt_checker.sv
`include "box_frustum_visibility_test_defines.svh"

module bfvt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic signed [bfvt_pkg::GRID_W-1:0] grid_x_i,
  input logic signed [bfvt_pkg::GRID_W-1:0] grid_y_i,
  input logic signed [bfvt_pkg::GRID_W-1:0] grid_z_i,
  input logic                             draw_allowed_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             visible_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [bfvt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [bfvt_pkg::REG_W-1:0]       cfg_data_i
);
  import bfvt_pkg::*;

  logic in_xfer;
  logic unused_fields;

  assign in_xfer = in_valid_i && in_ready_o;
  assign unused_fields = ^{grid_x_i, grid_y_i, grid_z_i, cfg_index_i, cfg_data_i};

  // The register port never pushes back.
  `BFVT_CHECK_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)

  // A free output side lets the whole pipeline take a new chunk.
  `BFVT_CHECK_NOW(a_ready_chain, out_ready_i, in_ready_o)

  // With the output side ready throughout, an accepted chunk reaches the output without waiting.
  `BFVT_CHECK_NEXT(a_latency, in_xfer ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_o)

  // A disabled chunk is always culled.
  `BFVT_CHECK_NEXT(a_disabled_culled, (in_xfer && !draw_allowed_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_o && !visible_o)

endmodule

bind box_frustum_visibility_test bfvt_checker u_bfvt_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bfvt_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 7;
  localparam int PIPE_DEPTH = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int BLOCKS_PER_PHASE = 5;
  localparam int CHUNKS_PER_BLOCK = 27;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE0 = 3'd0,
    REG_PLANE1 = 3'd1,
    REG_PLANE2 = 3'd2,
    REG_PLANE3 = 3'd3,
    REG_PLANE4 = 3'd4,
    REG_PLANE5 = 3'd5,
    REG_VIEW   = 3'd6,
    REG_UNUSED = 3'd7
  } reg_index_e;

  // Flavors of random frustum setups.
  typedef enum int {
    SETUP_AIMED,
    SETUP_WILD,
    SETUP_OPEN
  } setup_kind_e;

  typedef struct {
    logic visible;
    int   tag;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [GRID_W-1:0] grid_x_i = '0;
  logic signed [GRID_W-1:0] grid_y_i = '0;
  logic signed [GRID_W-1:0] grid_z_i = '0;
  logic draw_allowed_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic visible_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [REG_W-1:0] cfg_data_i = '0;

  // Shadow copy of the register file used by the predictor.
  logic [REG_W-1:0] shadow_regs [NUM_REGS];

  verdict_t pending_verdicts[$];
  int chunks_sent = 0;
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  box_frustum_visibility_test dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .grid_x_i       (grid_x_i),
    .grid_y_i       (grid_y_i),
    .grid_z_i       (grid_z_i),
    .draw_allowed_i (draw_allowed_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .visible_o      (visible_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The result side stalls at random according to the current idle rate.
  always @(negedge clk) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Compare every result transfer with the oldest pending verdict.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0b with no chunk pending", visible_o));
      end else begin
        if (visible_o !== pending_verdicts[0].visible) begin
          report_mismatch($sformatf("chunk %0d: visible %0b, predicted %0b",
                                    pending_verdicts[0].tag, visible_o,
                                    pending_verdicts[0].visible));
        end
        void'(pending_verdicts.pop_front());
      end
    end
  end

  function automatic longint field16(input logic [REG_W-1:0] r, input int slot);
    return longint'($signed(r[FIELD_W*slot +: FIELD_W]));
  endfunction

  // Exact integer version of the cube and plane tests.
  function automatic logic predict_visibility(input logic signed [GRID_W-1:0] gx,
                                              input logic signed [GRID_W-1:0] gy,
                                              input logic signed [GRID_W-1:0] gz,
                                              input logic draw);
    longint lo [NUM_AXES];
    longint hi [NUM_AXES];
    longint edge_len [NUM_AXES];
    logic signed [GRID_W-1:0] grid [NUM_AXES];
    longint acc;
    longint n;
    longint cam;
    longint far_range;
    logic vis;
    edge_len[0] = EDGE_X;
    edge_len[1] = EDGE_Y;
    edge_len[2] = EDGE_Z;
    grid[0] = gx;
    grid[1] = gy;
    grid[2] = gz;
    vis = draw;
    far_range = longint'(shadow_regs[REG_VIEW][REG_W-1 -: FIELD_W]);
    for (int a = 0; a < NUM_AXES; a++) begin
      lo[a] = longint'(grid[a]) * edge_len[a];
      hi[a] = lo[a] + edge_len[a];
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      cam = field16(shadow_regs[REG_VIEW], a);
      if (hi[a] < cam - far_range || lo[a] > cam + far_range) begin
        vis = 1'b0;
      end
    end
    // A plane culls when even its most positive corner is below zero.
    for (int p = 0; p < NUM_PLANES; p++) begin
      acc = field16(shadow_regs[p], RANGE_SLOT) * (longint'(1) << FRAC_W);
      for (int a = 0; a < NUM_AXES; a++) begin
        n = field16(shadow_regs[p], a);
        acc += n * ((n > 0) ? hi[a] : lo[a]);
      end
      if (acc < 0) begin
        vis = 1'b0;
      end
    end
    return vis;
  endfunction

  function automatic logic [REG_W-1:0] pack_fields(input int f0, input int f1,
                                                   input int f2, input int f3);
    return {f3[FIELD_W-1:0], f2[FIELD_W-1:0], f1[FIELD_W-1:0], f0[FIELD_W-1:0]};
  endfunction

  function automatic int clamp(input int v, input int lo_lim, input int hi_lim);
    return (v < lo_lim) ? lo_lim : ((v > hi_lim) ? hi_lim : v);
  endfunction

  // One configuration transfer; the shadow copy follows the block.
  task automatic write_register(input reg_index_e idx, input logic [REG_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk); while (!cfg_ready_o);
    if (int'(idx) < NUM_REGS) begin
      shadow_regs[idx] = data;
    end
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  // Offer one chunk and wait for its transfer; valid stays high afterwards.
  task automatic send_chunk(input int gx, input int gy, input int gz, input bit draw);
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk);
    end
    in_valid_i = 1'b1;
    grid_x_i = gx[GRID_W-1:0];
    grid_y_i = gy[GRID_W-1:0];
    grid_z_i = gz[GRID_W-1:0];
    draw_allowed_i = draw;
    do @(posedge clk); while (!in_ready_o);
    v.visible = predict_visibility(grid_x_i, grid_y_i, grid_z_i, draw_allowed_i);
    v.tag = chunks_sent;
    pending_verdicts.push_back(v);
    chunks_sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait for every pending verdict to come back.
  task automatic drain_pipeline();
    int waited;
    in_valid_i = 1'b0;
    waited = 0;
    while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (PIPE_DEPTH + 2) @(negedge clk);
    if (pending_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
      pending_verdicts.delete();
    end
  endtask

  // Registers at their reset value: zero range around the origin, planes all zero.
  task automatic test_reset_state();
    send_chunk(0, 0, 0, 1'b1);
    send_chunk(-1, -1, -1, 1'b1);
    send_chunk(1, 0, 0, 1'b1);
    send_chunk(0, 0, 0, 1'b0);
  endtask

  // Widest cube, so that only the grid extremes and the enable flag matter.
  task automatic test_grid_extremes();
    drain_pipeline();
    write_register(REG_VIEW, pack_fields(0, 0, 0, 16'hFFFF));
    send_chunk(-1024, -1024, -1024, 1'b1);
    send_chunk(1023, 1023, 1023, 1'b1);
    send_chunk(-1024, 1023, -1024, 1'b1);
    send_chunk(1023, -1024, 1023, 1'b0);
  endtask

  // Boxes just touching and just leaving both x faces, and touching or leaving the y and z faces.
  task automatic test_range_faces();
    drain_pipeline();
    write_register(REG_VIEW, pack_fields(16, 16, 16, 32));
    send_chunk(-2, 0, 0, 1'b1);
    send_chunk(-3, 0, 0, 1'b1);
    send_chunk(3, 0, 0, 1'b1);
    send_chunk(4, 0, 0, 1'b1);
    send_chunk(0, -3, 0, 1'b1);
    send_chunk(0, 0, 4, 1'b1);
    send_chunk(0, 3, -2, 1'b1);
  endtask

  // Plane value exactly zero, one unit below, negative normals, extreme coefficients.
  task automatic test_plane_edges();
    drain_pipeline();
    write_register(REG_VIEW, pack_fields(0, 0, 0, 16'hFFFF));
    write_register(REG_PLANE0, pack_fields(16'h4000, 0, 0, -16));
    send_chunk(0, 0, 0, 1'b1);
    send_chunk(-1, 0, 0, 1'b1);
    drain_pipeline();
    write_register(REG_PLANE0, pack_fields(16'h4000, 0, 0, -17));
    send_chunk(0, 0, 0, 1'b1);
    drain_pipeline();
    // A zero plane never culls; plane 1 faces toward negative x.
    write_register(REG_PLANE0, '0);
    write_register(REG_PLANE1, pack_fields(16'hC000, 0, 0, 0));
    send_chunk(0, 0, 0, 1'b1);
    send_chunk(1, 0, 0, 1'b1);
    drain_pipeline();
    write_register(REG_PLANE1, '0);
    write_register(REG_PLANE5, pack_fields(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000));
    send_chunk(1023, 1023, 1023, 1'b1);
    send_chunk(-1024, -1024, -1024, 1'b1);
    drain_pipeline();
    // An index past the register file must change nothing.
    write_register(REG_UNUSED, {REG_W{1'b1}});
    write_register(REG_PLANE5, '0);
    send_chunk(0, 0, 0, 1'b1);
  endtask

  // Load a fresh frustum of the given flavor into every register.
  task automatic load_frustum(input setup_kind_e kind, output int cam [NUM_AXES],
                              output int spread);
    int n [NUM_AXES];
    int far_range;
    int d;
    logic [REG_W-1:0] word;
    for (int a = 0; a < NUM_AXES; a++) begin
      cam[a] = int'($urandom_range(0, 4000)) - 2000;
    end
    far_range = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 800));
    spread = far_range / EDGE_MAX + 3;
    case (kind)
      SETUP_AIMED: begin
        write_register(REG_VIEW, pack_fields(cam[0], cam[1], cam[2], far_range));
        // Planes pass near the camera, mostly with the camera on the inner side.
        for (int p = 0; p < NUM_PLANES; p++) begin
          if ($urandom_range(0, 4) == 0) begin
            word = '0;
          end else begin
            for (int a = 0; a < NUM_AXES; a++) begin
              n[a] = int'($urandom_range(0, 32768)) - 16384;
            end
            d = -((n[0] * cam[0] + n[1] * cam[1] + n[2] * cam[2]) / (1 << FRAC_W));
            d = d + int'($urandom_range(0, 96 + far_range / 2)) - 32;
            word = pack_fields(n[0], n[1], n[2], clamp(d, -32768, 32767));
          end
          write_register(reg_index_e'(p), word);
        end
      end
      SETUP_WILD: begin
        for (int p = 0; p <= NUM_REGS; p++) begin
          write_register(reg_index_e'(p), {$urandom, $urandom});
        end
      end
      default: begin
        write_register(REG_VIEW, {16'hFFFF, 16'($urandom_range(0, 16'hFFFF)),
                                  16'($urandom_range(0, 16'hFFFF)),
                                  16'($urandom_range(0, 16'hFFFF))});
        for (int p = 0; p < NUM_PLANES; p++) begin
          write_register(reg_index_e'(p), '0);
        end
      end
    endcase
  endtask

  function automatic int grid_near(input int cam_coord, input int spread);
    int g;
    g = cam_coord / EDGE_MAX + int'($urandom_range(0, 2 * spread)) - spread;
    return clamp(g, -1024, 1023);
  endfunction

  // Blocks of random chunks, each block under a freshly loaded frustum.
  task automatic test_random_frustum();
    setup_kind_e kind;
    int cam [NUM_AXES];
    int spread;
    bit draw;
    for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
      kind = (blk < 3) ? SETUP_AIMED : ((blk == 3) ? SETUP_WILD : SETUP_OPEN);
      drain_pipeline();
      load_frustum(kind, cam, spread);
      for (int i = 0; i < CHUNKS_PER_BLOCK; i++) begin
        draw = ($urandom_range(0, 99) < 85);
        if (kind == SETUP_AIMED && $urandom_range(0, 99) < 85) begin
          send_chunk(grid_near(cam[0], spread), grid_near(cam[1], spread),
                     grid_near(cam[2], spread), draw);
        end else begin
          send_chunk(int'($urandom_range(0, 2047)) - 1024,
                     int'($urandom_range(0, 2047)) - 1024,
                     int'($urandom_range(0, 2047)) - 1024, draw);
        end
      end
    end
  endtask

  initial begin
    for (int r = 0; r < NUM_REGS; r++) begin
      shadow_regs[r] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 48;
    test_reset_state();
    test_grid_extremes();
    test_range_faces();
    test_plane_edges();
    test_random_frustum();

    send_idle_pct = 48;
    recv_idle_pct = 30;
    test_random_frustum();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frustum();

    drain_pipeline();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/bfvt_pkg.sv
sv/bfvt_plane.sv
sv/box_frustum_visibility_test.sv
sv/bfvt_checker.sv
tb/sv/testbench.sv
